[rtl/ioct_pkg.sv]
// Shared constants for the in-order commit tracker: field widths, op and
// result-kind codes, and parameter defaults. No dependencies.
package ioct_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CONN_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned SEQ_W  = 32;

  // Parameter defaults
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned HANDLE_BITS_DEF = 8;

  // Request op codes
  localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FORCE    = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEFER    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_SLOT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd5;

endpackage

[rtl/ioct_entry_ram.sv]
// Entry payload RAM: sequence number and connection handle per slot.
// One write port, one read port, registered read data. No dependencies.
module ioct_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ioct_ctrl.sv]
// Tracker sequencer: valid/ready flags, pointers, sequence counter, retire
// scan and the result register. Depends on ioct_pkg; drives ioct_entry_ram.
module ioct_ctrl
  import ioct_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned MW = SEQ_W + HANDLE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [CONN_W-1:0] conn_handle_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic [SEQ_W-1:0]  out_seq_o,
  output logic [CONN_W-1:0] out_conn_o,
  output logic              last_o,
  // Entry RAM
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [MW-1:0]     mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [MW-1:0]     mem_rdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEFER = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [2:0]             state_q, state_d;
  logic [DEPTH-1:0]       valid_q, valid_d;
  logic [DEPTH-1:0]       ready_q, ready_d;
  logic [AW-1:0]          head_q, head_d;
  logic [AW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          occ_q, occ_d;
  logic [SEQ_W-1:0]       seq_q, seq_d;
  // Scan state
  logic [AW-1:0]          scan_q, scan_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   force_q, force_d;
  logic                   found_q, found_d;
  logic [AW-1:0]          keep_q, keep_d;
  logic [AW-1:0]          slot_q, slot_d;
  // Staged commit, held until we know whether another one follows
  logic                   stg_valid_q, stg_valid_d;
  logic [AW-1:0]          stg_slot_q, stg_slot_d;
  logic [SEQ_W-1:0]       stg_seq_q, stg_seq_d;
  logic [HANDLE_BITS-1:0] stg_conn_q, stg_conn_d;
  // Result register
  logic                   out_valid_q;
  logic [KIND_W-1:0]      kind_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [SEQ_W-1:0]       out_seq_q;
  logic [CONN_W-1:0]      out_conn_q;
  logic                   last_q;

  logic                   ld;
  logic [KIND_W-1:0]      ld_kind;
  logic [SLOT_W-1:0]      ld_slot;
  logic [SEQ_W-1:0]       ld_seq;
  logic [CONN_W-1:0]      ld_conn;
  logic                   ld_last;

  logic                   out_free;
  logic [AW-1:0]          slot_idx;
  logic                   slot_ok;
  logic [HANDLE_BITS-1:0] conn_m;
  logic [SEQ_W-1:0]       seq_nxt;
  logic [CW-1:0]          span;
  logic [SEQ_W-1:0]       rd_seq;
  logic [HANDLE_BITS-1:0] rd_conn;

  assign out_free = !out_valid_q || out_ready_i;
  assign slot_idx = AW'(slot_i);
  assign slot_ok  = (32'(slot_i) < DEPTH);
  assign conn_m   = HANDLE_BITS'(conn_handle_i);
  assign seq_nxt  = seq_q + 1'b1;
  assign rd_seq   = mem_rdata_i[MW-1 -: SEQ_W];
  assign rd_conn  = mem_rdata_i[HANDLE_BITS-1:0];

  // Number of slot positions from head to tail
  always_comb begin
    if (occ_q == '0) begin
      span = '0;
    end else if (head_q == tail_q) begin
      span = CW'(DEPTH);
    end else if (tail_q >= head_q) begin
      span = CW'(tail_q) - CW'(head_q);
    end else begin
      span = CW'(tail_q) + CW'(DEPTH) - CW'(head_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    ready_d     = ready_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    seq_d       = seq_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    force_d     = force_q;
    found_d     = found_q;
    keep_d      = keep_q;
    slot_d      = slot_q;
    stg_valid_d = stg_valid_q;
    stg_slot_d  = stg_slot_q;
    stg_seq_d   = stg_seq_q;
    stg_conn_d  = stg_conn_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = {seq_nxt, conn_m};
    mem_raddr_o = scan_q;
    ld          = 1'b0;
    ld_kind     = KIND_NONE;
    ld_slot     = '0;
    ld_seq      = '0;
    ld_conn     = '0;
    ld_last     = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_ready_o  = out_free;
        mem_raddr_o = slot_idx;
        if (in_valid_i && out_free) begin
          case (op_i)
            OP_CREATE: begin
              ld = 1'b1;
              if (occ_q != '0 && head_q == tail_q) begin
                ld_kind = KIND_FULL;
              end else begin
                mem_we_o        = 1'b1;
                seq_d           = seq_nxt;
                valid_d[tail_q] = 1'b1;
                ready_d[tail_q] = 1'b0;
                occ_d           = occ_q + 1'b1;
                tail_d          = ptr_inc(tail_q);
                ld_kind         = KIND_ALLOC;
                ld_slot         = SLOT_W'(tail_q);
                ld_seq          = seq_nxt;
                ld_conn         = CONN_W'(conn_m);
              end
            end
            OP_COMPLETE: begin
              if (!slot_ok || !valid_q[slot_idx]) begin
                ld      = 1'b1;
                ld_kind = KIND_BAD_SLOT;
                ld_slot = slot_i;
              end else begin
                ready_d[slot_idx] = 1'b1;
                if (slot_idx != head_q) begin
                  slot_d  = slot_idx;
                  state_d = S_DEFER;
                end else begin
                  scan_d      = head_q;
                  cnt_d       = span;
                  force_d     = 1'b0;
                  found_d     = 1'b0;
                  stg_valid_d = 1'b0;
                  state_d     = S_SCAN;
                end
              end
            end
            OP_FORCE: begin
              scan_d      = head_q;
              cnt_d       = span;
              force_d     = 1'b1;
              found_d     = 1'b0;
              stg_valid_d = 1'b0;
              state_d     = S_SCAN;
            end
            default: begin
              // unknown op: accepted, no result
            end
          endcase
        end
      end

      // Deferred completion: payload read lands in the cycle after accept
      S_DEFER: begin
        mem_raddr_o = slot_q;
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = KIND_DEFER;
          ld_slot = SLOT_W'(slot_q);
          ld_seq  = rd_seq;
          ld_conn = CONN_W'(rd_conn);
          state_d = S_IDLE;
        end
      end

      // Look at one position of the span per cycle; a ready entry first goes through S_EMIT
      S_SCAN: begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else if (!valid_q[scan_q]) begin
          scan_d = ptr_inc(scan_q);
          cnt_d  = cnt_q - 1'b1;
        end else if (!ready_q[scan_q]) begin
          if (!found_q) begin
            found_d = 1'b1;
            keep_d  = scan_q;
          end
          if (force_q) begin
            scan_d = ptr_inc(scan_q);
            cnt_d  = cnt_q - 1'b1;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_EMIT;
        end
      end

      // Retire the entry at scan_q; push any earlier staged commit out
      S_EMIT: begin
        if (!stg_valid_q || out_free) begin
          if (stg_valid_q) begin
            ld      = 1'b1;
            ld_kind = KIND_COMMIT;
            ld_slot = SLOT_W'(stg_slot_q);
            ld_seq  = stg_seq_q;
            ld_conn = CONN_W'(stg_conn_q);
            ld_last = 1'b0;
          end
          stg_valid_d     = 1'b1;
          stg_slot_d      = scan_q;
          stg_seq_d       = rd_seq;
          stg_conn_d      = rd_conn;
          valid_d[scan_q] = 1'b0;
          ready_d[scan_q] = 1'b0;
          occ_d           = occ_q - 1'b1;
          scan_d          = ptr_inc(scan_q);
          cnt_d           = cnt_q - 1'b1;
          state_d         = S_SCAN;
        end
      end

      // Final result and head settle
      S_FIN: begin
        if (out_free) begin
          ld = 1'b1;
          if (stg_valid_q) begin
            ld_kind = KIND_COMMIT;
            ld_slot = SLOT_W'(stg_slot_q);
            ld_seq  = stg_seq_q;
            ld_conn = CONN_W'(stg_conn_q);
          end else begin
            ld_kind = KIND_NONE;
          end
          stg_valid_d = 1'b0;
          head_d      = (occ_q == '0) ? tail_q : keep_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      ready_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      seq_q       <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ready_q     <= ready_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      seq_q       <= seq_d;
      stg_valid_q <= stg_valid_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    cnt_q      <= cnt_d;
    force_q    <= force_d;
    found_q    <= found_d;
    keep_q     <= keep_d;
    slot_q     <= slot_d;
    stg_slot_q <= stg_slot_d;
    stg_seq_q  <= stg_seq_d;
    stg_conn_q <= stg_conn_d;
    if (ld) begin
      kind_q     <= ld_kind;
      out_slot_q <= ld_slot;
      out_seq_q  <= ld_seq;
      out_conn_q <= ld_conn;
      last_q     <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_slot_o  = out_slot_q;
  assign out_seq_o   = out_seq_q;
  assign out_conn_o  = out_conn_q;
  assign last_o      = last_q;

endmodule

[rtl/in_order_commit_tracker.sv]
// In-order commit tracker (reorder buffer with in-order retire). A create
// request takes the tail slot and answers with its slot and sequence number
// (starting at 1); a complete request marks a slot ready and either answers
// deferred or retires the ready run at the head; a force request retires
// every ready entry in age order. The results of one request come out in
// order, the final one with last set. An unknown request is accepted and
// answers nothing. A retire request scans the live span one slot position
// per cycle, apart from a pass through S_EMIT for each retired entry to
// read its payload from the entry RAM, and waits on result back-pressure.
// Depends on ioct_pkg, ioct_ctrl and ioct_entry_ram.
module in_order_commit_tracker
  import ioct_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [CONN_W-1:0] conn_handle_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic [SEQ_W-1:0]  out_seq_o,
  output logic [CONN_W-1:0] out_conn_o,
  output logic              last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned MW = SEQ_W + HANDLE_BITS;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  // Sequencer and flags
  ioct_ctrl #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .slot_i        (slot_i),
    .conn_handle_i (conn_handle_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_slot_o    (out_slot_o),
    .out_seq_o     (out_seq_o),
    .out_conn_o    (out_conn_o),
    .last_o        (last_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // Entry payload storage
  ioct_entry_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[sim/tb_in_order_commit_tracker.sv]
// Testbench for in_order_commit_tracker: directed and random create, complete
// and force requests, checked against a behavioral scoreboard of the buffer.
// Depends on ioct_pkg and the in_order_commit_tracker RTL.
module tb_in_order_commit_tracker;
  import ioct_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned RAND_REQUESTS = 360;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq;
    logic [CONN_W-1:0] conn;
    logic              last;
  } commit_result_t;

  // Behavioral copy of the buffer; holds the results still owed by the DUT
  class commit_scoreboard;
    bit                live_q [DEPTH];
    bit                done_q [DEPTH];
    logic [SEQ_W-1:0]  seq_mem [DEPTH];
    logic [CONN_W-1:0] conn_mem [DEPTH];
    int unsigned       head_pos;
    int unsigned       tail_pos;
    int unsigned       live_count;
    logic [SEQ_W-1:0]  seq_ctr;
    commit_result_t    expected_q [$];
    commit_result_t    batch_q [$];
    int unsigned       errors;

    function new();
      foreach (live_q[i]) begin
        live_q[i] = 1'b0;
        done_q[i] = 1'b0;
      end
      head_pos   = 0;
      tail_pos   = 0;
      live_count = 0;
      seq_ctr    = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void emit_result(logic [KIND_W-1:0] kind, int unsigned slot,
                              logic [SEQ_W-1:0] seq, logic [CONN_W-1:0] conn);
      commit_result_t r;
      r.kind = kind;
      r.slot = slot[SLOT_W-1:0];
      r.seq  = seq;
      r.conn = conn;
      r.last = 1'b0;
      batch_q.push_back(r);
    endfunction

    // Positions covered from head to tail; a full buffer has head == tail
    function int unsigned span_length();
      if (live_count == 0) return 0;
      if (head_pos == tail_pos) return DEPTH;
      return (tail_pos + DEPTH - head_pos) % DEPTH;
    endfunction

    function void retire_entry(int unsigned p);
      emit_result(KIND_COMMIT, p, seq_mem[p], conn_mem[p]);
      live_q[p] = 1'b0;
      done_q[p] = 1'b0;
      live_count--;
    endfunction

    // Head skips holes; an empty buffer parks it on the tail
    function void settle_head();
      if (live_count == 0) begin
        head_pos = tail_pos;
        return;
      end
      while (!live_q[head_pos]) head_pos = (head_pos + 1) % DEPTH;
    endfunction

    // Head of the buffer a third of the time, else any live slot; any slot if none is live
    function logic [SLOT_W-1:0] pick_live_slot();
      int unsigned live [$];
      for (int unsigned i = 0; i < DEPTH; i++)
        if (live_q[i]) live.push_back(i);
      if (live.size() == 0) return SLOT_W'($urandom_range(0, DEPTH - 1));
      if ($urandom_range(0, 2) == 0) return SLOT_W'(head_pos);
      return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    // Update the buffer for an accepted request and queue its results
    function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                               logic [CONN_W-1:0] conn);
      int unsigned len;
      int unsigned p;
      commit_result_t r;
      batch_q.delete();
      case (op)
        OP_CREATE: begin
          if (live_count > 0 && head_pos == tail_pos) begin
            emit_result(KIND_FULL, 0, '0, '0);
          end else begin
            p = tail_pos;
            seq_ctr = seq_ctr + 1;
            live_q[p]   = 1'b1;
            done_q[p]   = 1'b0;
            seq_mem[p]  = seq_ctr;
            conn_mem[p] = conn;
            live_count++;
            tail_pos = (tail_pos + 1) % DEPTH;
            emit_result(KIND_ALLOC, p, seq_ctr, conn);
          end
        end
        OP_COMPLETE: begin
          if (int'(slot) >= DEPTH || !live_q[slot]) begin
            emit_result(KIND_BAD_SLOT, slot, '0, '0);
          end else begin
            done_q[slot] = 1'b1;
            if (slot != head_pos) begin
              emit_result(KIND_DEFER, slot, seq_mem[slot], conn_mem[slot]);
            end else begin
              // retire the ready run at the head, stop at the first unready entry
              len = span_length();
              for (int unsigned k = 0; k < len; k++) begin
                p = (head_pos + k) % DEPTH;
                if (!live_q[p]) continue;
                if (!done_q[p]) break;
                retire_entry(p);
              end
              settle_head();
            end
          end
        end
        OP_FORCE: begin
          len = span_length();
          for (int unsigned k = 0; k < len; k++) begin
            p = (head_pos + k) % DEPTH;
            if (live_q[p] && done_q[p]) retire_entry(p);
          end
          settle_head();
          if (batch_q.size() == 0) emit_result(KIND_NONE, 0, '0, '0);
        end
        default: return;
      endcase
      foreach (batch_q[i]) begin
        r = batch_q[i];
        r.last = (i == batch_q.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [SEQ_W-1:0] exp_v,
                                logic [SEQ_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(commit_result_t act);
      commit_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d seq %0d conn 0x%0h last %0b",
               act.kind, act.slot, act.seq, act.conn, act.last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("kind", exp_r.kind, act.kind);
      compare_field("out_slot", exp_r.slot, act.slot);
      compare_field("out_seq", exp_r.seq, act.seq);
      compare_field("out_conn", exp_r.conn, act.conn);
      compare_field("last", exp_r.last, act.last);
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i          = '0;
  logic [SLOT_W-1:0] slot_i        = '0;
  logic [CONN_W-1:0] conn_handle_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [SLOT_W-1:0] out_slot_o;
  logic [SEQ_W-1:0]  out_seq_o;
  logic [CONN_W-1:0] out_conn_o;
  logic              last_o;

  commit_scoreboard sb;
  bit               send_calm = 1'b0;
  bit               recv_calm = 1'b0;
  int unsigned      hold_gap  = 0;

  in_order_commit_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .slot_i        (slot_i),
    .conn_handle_i (conn_handle_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_slot_o    (out_slot_o),
    .out_seq_o     (out_seq_o),
    .out_conn_o    (out_conn_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Drive one request and hold it until accepted; drop valid if a gap follows
  task automatic send_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                              logic [CONN_W-1:0] conn);
    repeat (hold_gap) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    op_i          <= op;
    slot_i        <= slot;
    conn_handle_i <= conn;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, slot, conn);
    hold_gap = draw_gap(send_calm);
    if (hold_gap > 0) in_valid_i <= 1'b0;
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic drain_results();
    if (hold_gap == 0) begin
      in_valid_i <= 1'b0;
      hold_gap = 1;
    end
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall before each result
  initial begin : result_sink
    int unsigned stall;
    commit_result_t act;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      act.kind = kind_o;
      act.slot = out_slot_o;
      act.seq  = out_seq_o;
      act.conn = out_conn_o;
      act.last = last_o;
      sb.check_result(act);
    end
  end

  initial begin : stimulus
    int unsigned made;
    int unsigned in_phase;
    int unsigned create_w;
    int unsigned r;
    int unsigned s;
    logic [CONN_W-1:0] c;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty force, bad slot, unknown op, fill to full
    send_request(OP_FORCE, 4'd0, 8'h00);
    send_request(OP_COMPLETE, 4'd15, 8'h00);
    send_request(OP_UNUSED, 4'd15, 8'hff);
    for (int unsigned i = 0; i < DEPTH; i++) begin
      c = (i == 0) ? 8'h00 : (i == DEPTH - 1) ? 8'hff : CONN_W'($urandom_range(0, 255));
      send_request(OP_CREATE, SLOT_W'(i), c);
    end
    send_request(OP_CREATE, 4'd0, 8'h5a);
    // deferred completions, then a force that leaves holes
    send_request(OP_COMPLETE, 4'd5, 8'h00);
    send_request(OP_COMPLETE, 4'd3, 8'h00);
    send_request(OP_FORCE, 4'd0, 8'h00);
    // head retire alone, then a run that skips a hole
    send_request(OP_COMPLETE, 4'd0, 8'h00);
    send_request(OP_COMPLETE, 4'd2, 8'h00);
    send_request(OP_COMPLETE, 4'd1, 8'h00);
    drain_results();

    // Random phases with varying create pressure and idling
    made = 0;
    while (made < RAND_REQUESTS) begin
      r = $urandom_range(0, 2);
      create_w  = (r == 0) ? 20 : (r == 1) ? 40 : 62;
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      in_phase  = 0;
      while (in_phase < 40 && made < RAND_REQUESTS) begin
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        c = CONN_W'($urandom_range(0, 255));
        if (r < create_w) begin
          send_request(OP_CREATE, SLOT_W'($urandom_range(0, 15)), c);
        end else if (s < 72) begin
          send_request(OP_COMPLETE, sb.pick_live_slot(), c);
        end else if (s < 82) begin
          send_request(OP_COMPLETE, SLOT_W'($urandom_range(0, 15)), c);
        end else if (s < 94) begin
          send_request(OP_FORCE, SLOT_W'($urandom_range(0, 15)), c);
        end else begin
          send_request(OP_UNUSED, SLOT_W'($urandom_range(0, 15)), c);
          continue;
        end
        made++;
        in_phase++;
      end
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    // Wind down: everything owed, then quiet before the verdict
    drain_results();
    repeat (3 * DEPTH + 16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_in_order_commit_tracker passed");
    end else begin
      $display("tb_in_order_commit_tracker failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb_in_order_commit_tracker failed");
    $finish;
  end

endmodule
